@@ design/mpq_pkg.sv @@
package mpq_pkg;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_ENQUEUED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_DUPLICATE = 3'd2,
    STAT_DEQUEUED  = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ENQ_SCAN,
    SEQ_DEQ_SCAN,
    SEQ_DEQ_SHIFT,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] entry_id;
    logic [7:0] entry_priority;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_id;
    logic [7:0] out_priority;
    logic       now_empty;
  } rsp_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } slot_t;

  // sequencer handshake toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } seq_status_t;

endpackage

@@ design/mpq_ram.sv @@
module mpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/mpq_seq.sv @@
module mpq_seq #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mpq_pkg::req_t        req,
  input  logic                 take,
  output mpq_pkg::seq_status_t stat,
  output mpq_pkg::rsp_t        result
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  mpq_pkg::seq_state_t state, state_next;

  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] pidx;
  logic [IDX_W-1:0] best;
  logic [7:0]       best_prio;
  logic [7:0]       best_id;
  logic [7:0]       cur_id;
  logic [7:0]       cur_prio;
  mpq_pkg::rsp_t    res;

  logic             issue;
  logic             scan_end;
  logic             match;
  logic             better;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  mpq_pkg::slot_t   wr_data;
  mpq_pkg::slot_t   rd_data;
  logic             occ_full;

  mpq_ram #(
    .WIDTH($bits(mpq_pkg::slot_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(cnt[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign occ_full = (occ == OCC_W'(QUEUE_DEPTH));

  // compare logic and shared RAM port control
  always_comb begin
    issue    = 1'b0;
    match    = 1'b0;
    better   = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = occ[IDX_W-1:0];
    wr_data  = '{id: cur_id, prio: cur_prio};
    case (state)
      mpq_pkg::SEQ_ENQ_SCAN: begin
        issue = (cnt < occ);
        match = pend && (rd_data.id == cur_id);
      end
      mpq_pkg::SEQ_DEQ_SCAN: begin
        issue  = (cnt < occ);
        better = pend && ((pidx == '0) || (rd_data.prio < best_prio));
      end
      mpq_pkg::SEQ_DEQ_SHIFT: begin
        issue = (cnt < occ);
      end
      default: begin
      end
    endcase
    scan_end = !issue && !pend;
    case (state)
      mpq_pkg::SEQ_ENQ_SCAN: begin
        wr_en = scan_end;
      end
      mpq_pkg::SEQ_DEQ_SHIFT: begin
        // close the gap: entry read from pidx moves down one slot
        wr_en   = pend;
        wr_addr = pidx - IDX_W'(1);
        wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      mpq_pkg::SEQ_IDLE: begin
        if (start) begin
          case (req.cmd)
            mpq_pkg::CMD_ENQUEUE: begin
              state_next = occ_full ? mpq_pkg::SEQ_DONE : mpq_pkg::SEQ_ENQ_SCAN;
            end
            mpq_pkg::CMD_DEQUEUE: begin
              state_next = (occ == '0) ? mpq_pkg::SEQ_DONE : mpq_pkg::SEQ_DEQ_SCAN;
            end
            mpq_pkg::CMD_CLEAR: begin
              state_next = mpq_pkg::SEQ_DONE;
            end
            default: begin
              state_next = mpq_pkg::SEQ_IDLE;
            end
          endcase
        end
      end
      mpq_pkg::SEQ_ENQ_SCAN: begin
        if (match || scan_end) begin
          state_next = mpq_pkg::SEQ_DONE;
        end
      end
      mpq_pkg::SEQ_DEQ_SCAN: begin
        if (scan_end) begin
          state_next = mpq_pkg::SEQ_DEQ_SHIFT;
        end
      end
      mpq_pkg::SEQ_DEQ_SHIFT: begin
        if (scan_end) begin
          state_next = mpq_pkg::SEQ_DONE;
        end
      end
      mpq_pkg::SEQ_DONE: begin
        if (take) begin
          state_next = mpq_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = mpq_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpq_pkg::SEQ_IDLE;
      occ   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      case (state)
        mpq_pkg::SEQ_IDLE: begin
          if (start && (req.cmd == mpq_pkg::CMD_CLEAR)) begin
            occ <= '0;
          end
        end
        mpq_pkg::SEQ_ENQ_SCAN: begin
          if (!match && scan_end) begin
            occ <= occ + OCC_W'(1);
          end
        end
        mpq_pkg::SEQ_DEQ_SHIFT: begin
          if (scan_end) begin
            occ <= occ - OCC_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pidx <= cnt[IDX_W-1:0];
    if (issue) begin
      cnt <= cnt + OCC_W'(1);
    end
    case (state)
      mpq_pkg::SEQ_IDLE: begin
        cnt      <= '0;
        cur_id   <= req.entry_id;
        cur_prio <= req.entry_priority;
        if (req.cmd == mpq_pkg::CMD_ENQUEUE) begin
          res <= '{status: mpq_pkg::STAT_FULL, out_id: 8'd0, out_priority: 8'd0,
                   now_empty: (occ == '0)};
        end else if (req.cmd == mpq_pkg::CMD_DEQUEUE) begin
          res <= '{status: mpq_pkg::STAT_EMPTY, out_id: 8'd0, out_priority: 8'd0,
                   now_empty: 1'b1};
        end else begin
          res <= '{status: mpq_pkg::STAT_CLEARED, out_id: 8'd0, out_priority: 8'd0,
                   now_empty: 1'b1};
        end
      end
      mpq_pkg::SEQ_ENQ_SCAN: begin
        if (match) begin
          res.status    <= mpq_pkg::STAT_DUPLICATE;
          res.now_empty <= (occ == '0);
        end else if (scan_end) begin
          res.status    <= mpq_pkg::STAT_ENQUEUED;
          res.now_empty <= 1'b0;
        end
      end
      mpq_pkg::SEQ_DEQ_SCAN: begin
        if (better) begin
          best      <= pidx;
          best_prio <= rd_data.prio;
          best_id   <= rd_data.id;
        end
        if (scan_end) begin
          cnt <= OCC_W'(best) + OCC_W'(1);
        end
      end
      mpq_pkg::SEQ_DEQ_SHIFT: begin
        if (scan_end) begin
          res.status       <= mpq_pkg::STAT_DEQUEUED;
          res.out_id       <= best_id;
          res.out_priority <= best_prio;
          res.now_empty    <= (occ == OCC_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.idle = (state == mpq_pkg::SEQ_IDLE);
    stat.done = (state == mpq_pkg::SEQ_DONE);
    result    = res;
  end

endmodule

@@ design/min_priority_queue.sv @@
// Bounded min-priority queue of (id, priority) entries, up to QUEUE_DEPTH deep.
// Request channel: req_valid / req_stall carry one req beat (cmd, entry_id,
// entry_priority). Response channel: rsp_valid / rsp_stall carry one rsp
// beat (status, out_id, out_priority, now_empty). A beat moves on a rising
// edge with valid high and stall low. Each enqueue, dequeue or clear gives
// exactly one response beat; cmd 3 is taken and produces nothing.
// One request is in flight at a time; req_stall stays high until its result
// has moved into the response register.
// Clear, enqueue into a full queue and dequeue from an empty queue answer
// without touching the slot RAM. An enqueue scans the queued entries for
// its id and stops at a duplicate; a dequeue scans for the minimum, then
// shifts the tail down one slot to close the gap. The slot RAM has one
// read port and one separate write port.
// Reset empties the queue at once; slot contents are not cleared.
// A stalled response holds; the block takes the next request meanwhile and
// finishes it once the response register frees up.
module min_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mpq_pkg::rsp_t rsp
);

  mpq_pkg::seq_status_t seq_stat;
  mpq_pkg::rsp_t        seq_res;
  logic                 start;
  logic                 take;

  assign req_stall = !seq_stat.idle;
  assign start     = req_valid && !req_stall;
  assign take      = seq_stat.done && (!rsp_valid || !rsp_stall);

  mpq_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .take  (take),
    .stat  (seq_stat),
    .result(seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= seq_res;
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != mpq_pkg::STAT_DEQUEUED)
      |-> (rsp.out_id == 8'd0) && (rsp.out_priority == 8'd0))
    else $error("payload nonzero on non-dequeue beat");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp.status == mpq_pkg::STAT_CLEARED) ||
                  (rsp.status == mpq_pkg::STAT_EMPTY))
      |-> rsp.now_empty)
    else $error("clear or empty dequeue without now_empty");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    start && ((req.cmd == mpq_pkg::CMD_ENQUEUE) || (req.cmd == mpq_pkg::CMD_DEQUEUE) ||
              (req.cmd == mpq_pkg::CMD_CLEAR))
      |=> req_stall)
    else $error("sequencer did not go busy on a command");

  a_enq_not_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == mpq_pkg::STAT_ENQUEUED) |-> !rsp.now_empty)
    else $error("enqueue reported empty queue");
`endif

endmodule
